// File: hw/rtl/matrix4_multiply_assert.svh
// Assertion macros shared by the matrix multiply RTL.
// Each macro disappears when SYNTH is defined.
`ifndef MATRIX4_MULTIPLY_ASSERT_SVH
`define MATRIX4_MULTIPLY_ASSERT_SVH

`ifndef SYNTH

// Expression must hold at every clock edge outside reset.
`define MM4_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("mm4 assertion failed");

// Antecedent implies consequent in the same cycle.
`define MM4_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mm4 assertion failed");

// Antecedent implies consequent in the next cycle.
`define MM4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mm4 assertion failed");

`else

`define MM4_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define MM4_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MM4_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/mm4_pkg.sv
`default_nettype none

package mm4_pkg;

	// matrix geometry and fixed-point format
	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int CELLS     = DIM * DIM;
	localparam int DIM_W     = $clog2(DIM);
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int IDX_W     = 4;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + $clog2(DIM);

	// transaction queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified load transaction
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;
		logic              last;
	} mm4_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/matrix4_multiply.sv
// 4x4 Q16.16 matrix product, parent times local, column-major.
// Loads enter a 4-deep queue at one per cycle while not busy; busy is high while it is full.
// A last load starts the product when the back pops it, which it does only while idle; each result
// sums four terms from the single 32x32 multiplier, and results come out in index order.
// Results are strobed for one cycle each; the receiver cannot stall them.
// arst_n clears the queue and the sequencer; store contents are undefined until written.
`default_nettype none

module matrix4_multiply (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [mm4_pkg::IDX_W-1:0]   element_index,
	input  wire logic signed [mm4_pkg::DATA_W-1:0] left_value,
	input  wire logic signed [mm4_pkg::DATA_W-1:0] right_value,
	input  wire logic                        last_element,
	output logic                             result_strobe,
	output logic [mm4_pkg::IDX_W-1:0]        product_index,
	output logic signed [mm4_pkg::DATA_W-1:0] product_value,
	output logic                             saturated,
	output logic                             last_result
);

	import mm4_pkg::*;

	logic      q_valid;
	logic      q_pop;
	mm4_item_t q_item;

	// front: accept and queue load transactions
	mm4_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.element_index (element_index),
		.left_value    (left_value),
		.right_value   (right_value),
		.last_element  (last_element),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// back: store writes and product sequencing
	mm4_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.result_strobe (result_strobe),
		.product_index (product_index),
		.product_value (product_value),
		.saturated     (saturated),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

// File: hw/rtl/mm4_front.sv
`default_nettype none
`include "matrix4_multiply_assert.svh"

module mm4_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [mm4_pkg::IDX_W-1:0] element_index,
	input  wire logic [mm4_pkg::DATA_W-1:0] left_value,
	input  wire logic [mm4_pkg::DATA_W-1:0] right_value,
	input  wire logic                      last_element,
	output logic                           q_valid,
	output mm4_pkg::mm4_item_t             q_item,
	input  wire logic                      q_pop
);

	import mm4_pkg::*;

	mm4_item_t         queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              do_pop;
	mm4_item_t         item_in;

	// classify: positions past the store write nothing
	always_comb begin
		item_in.wr_en = (int'(element_index) < CELLS);
		item_in.addr  = ADDR_W'(element_index);
		item_in.left  = left_value;
		item_in.right = right_value;
		item_in.last  = last_element;
	end

	assign busy    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign do_pop  = q_pop && q_valid;
	assign q_item  = queue_q[rptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= item_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MM4_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
	`MM4_ASSERT_NEXT(a_push_only_grows, clk, arst_n, push && !do_pop, count_q == $past(count_q) + 1'b1)
	`MM4_ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, q_pop, q_valid)

endmodule

`default_nettype wire

// File: hw/rtl/mm4_back.sv
`default_nettype none
`include "matrix4_multiply_assert.svh"

module mm4_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire mm4_pkg::mm4_item_t          q_item,
	output logic                             q_pop,
	output logic                             result_strobe,
	output logic [mm4_pkg::IDX_W-1:0]        product_index,
	output logic signed [mm4_pkg::DATA_W-1:0] product_value,
	output logic                             saturated,
	output logic                             last_result
);

	import mm4_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [DIM_W-1:0]   k_q;
	logic [DIM_W-1:0]   r_q;
	logic [DIM_W-1:0]   c_q;
	logic               k_end;
	logic               r_end;
	logic               c_end;
	logic               issue;
	logic [ADDR_W-1:0]  left_addr;
	logic [ADDR_W-1:0]  right_addr;
	logic [ADDR_W-1:0]  elem_addr;

	logic [DATA_W-1:0]  left_mem  [CELLS];
	logic [DATA_W-1:0]  right_mem [CELLS];

	// stage 1: store read data
	logic [DATA_W-1:0]  left_s1;
	logic [DATA_W-1:0]  right_s1;
	logic               valid_s1;
	logic               kfirst_s1;
	logic               klast_s1;
	logic [ADDR_W-1:0]  elem_s1;
	logic               fin_s1;
	// stage 2: product
	logic signed [PROD_W-1:0] prod_s2;
	logic               valid_s2;
	logic               kfirst_s2;
	logic               klast_s2;
	logic [ADDR_W-1:0]  elem_s2;
	logic               fin_s2;
	// stage 3: accumulate
	logic signed [SUM_W-1:0] acc_q;
	logic               done_s3;
	logic [ADDR_W-1:0]  elem_s3;
	logic               fin_s3;

	logic signed [SUM_W-1:0]  shifted;
	logic [SUM_W-DATA_W:0]    top_bits;
	logic                     fits;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign issue = (state_q == ST_RUN);
	assign k_end = (k_q == DIM_W'(DIM - 1));
	assign r_end = (r_q == DIM_W'(DIM - 1));
	assign c_end = (c_q == DIM_W'(DIM - 1));

	// left[k*DIM + r], right[c*DIM + k], result at c*DIM + r
	assign left_addr  = ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(r_q);
	assign right_addr = ADDR_W'(c_q) * ADDR_W'(DIM) + ADDR_W'(k_q);
	assign elem_addr  = ADDR_W'(c_q) * ADDR_W'(DIM) + ADDR_W'(r_q);

	// sequencer: one store load per pop, then one term per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			r_q     <= '0;
			c_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					r_q <= '0;
					c_q <= '0;
					if (q_pop && q_item.last) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_end ? '0 : k_q + 1'b1;
					if (k_end) begin
						r_q <= r_end ? '0 : r_q + 1'b1;
						if (r_end) begin
							c_q <= c_q + 1'b1;
							if (c_end) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stores: written on pop, read with registered data
	always_ff @(posedge clk) begin
		if (q_pop && q_item.wr_en) begin
			left_mem[q_item.addr]  <= q_item.left;
			right_mem[q_item.addr] <= q_item.right;
		end
		left_s1  <= left_mem[left_addr];
		right_s1 <= right_mem[right_addr];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		kfirst_s1 <= (k_q == '0);
		klast_s1  <= k_end;
		elem_s1   <= elem_addr;
		fin_s1    <= c_end && r_end;
		prod_s2   <= $signed(left_s1) * $signed(right_s1);
		kfirst_s2 <= kfirst_s1;
		klast_s2  <= klast_s1;
		elem_s2   <= elem_s1;
		fin_s2    <= fin_s1;
		elem_s3   <= elem_s2;
		fin_s3    <= fin_s2;
		if (valid_s2) begin
			acc_q <= kfirst_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);
		end
	end

	// round toward minus infinity, then clip to 32 bits
	always_comb begin
		shifted  = acc_q >>> FRAC_BITS;
		top_bits = shifted[SUM_W-1:DATA_W-1];
		fits     = (&top_bits) || !(|top_bits);
	end

	// pipeline control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			done_s3       <= 1'b0;
			result_strobe <= 1'b0;
			last_result   <= 1'b0;
		end else begin
			valid_s1      <= issue;
			valid_s2      <= valid_s1;
			done_s3       <= valid_s2 && klast_s2;
			result_strobe <= done_s3;
			last_result   <= done_s3 && fin_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			product_index <= IDX_W'(elem_s3);
			saturated     <= !fits;
			if (fits) begin
				product_value <= shifted[DATA_W-1:0];
			end else if (acc_q[SUM_W-1]) begin
				product_value <= {1'b1, {(DATA_W - 1){1'b0}}};
			end else begin
				product_value <= {1'b0, {(DATA_W - 1){1'b1}}};
			end
		end
	end

	`MM4_ASSERT_IMPLY(a_last_index, clk, arst_n, last_result, result_strobe && product_index == IDX_W'(CELLS - 1))
	`MM4_ASSERT_NEXT(a_strobe_spaced, clk, arst_n, result_strobe, !result_strobe)
	`MM4_ASSERT_NEXT(a_run_ends, clk, arst_n, issue && k_end && r_end && c_end, state_q == ST_IDLE)

endmodule

`default_nettype wire
